// ===== src/formation_potential_field_steering_defines.svh =====
// Assertion macros for the formation steering block.
// Used by the controller; no other dependencies.
`ifndef FORMATION_POTENTIAL_FIELD_STEERING_DEFINES_SVH
`define FORMATION_POTENTIAL_FIELD_STEERING_DEFINES_SVH
`ifndef SYNTHESIS
`define FPFS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("fpfs check failed");
`define FPFS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("fpfs check failed");
`else
`define FPFS_ASSERT(lbl, clk, rst, prop)
`define FPFS_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== src/fpfs_pkg.sv =====
// Shared types, constants and tables for the formation steering block.
// No dependencies.
`default_nettype none
package fpfs_pkg;

   localparam int ROBOT_COUNT  = 4;
   localparam int FORCE_EPS    = 66;
   localparam int PI_Q16       = 205887;
   localparam int PI_Q12       = 12868;
   localparam int TWO_PI_Q12   = 25736;
   localparam int CORDIC_STEPS = 17;
   localparam int DIV_STEPS    = 17;
   localparam int ROOT_STEPS   = 32;

   localparam logic [4:0] ROOT_LAST   = 5'(ROOT_STEPS - 1);
   localparam logic [4:0] DIV_LAST    = 5'(DIV_STEPS - 1);
   localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_STEPS - 1);
   localparam logic [4:0] ROBOT_LAST  = 5'(ROBOT_COUNT - 1);

   localparam logic [1:0] MODE_POSE = 2'd0;
   localparam logic [1:0] MODE_TICK = 2'd1;
   localparam logic [1:0] MODE_EXCL = 2'd2;
   localparam logic [1:0] MODE_GOAL = 2'd3;

   localparam logic [2:0] CSR_OWN    = 3'd0;
   localparam logic [2:0] CSR_SCALE  = 3'd1;
   localparam logic [2:0] CSR_AGAIN  = 3'd2;
   localparam logic [2:0] CSR_CGAIN  = 3'd3;
   localparam logic [2:0] CSR_TGAIN  = 3'd4;
   localparam logic [2:0] CSR_SGAIN  = 3'd5;
   localparam logic [2:0] CSR_LIMITS = 3'd6;
   localparam logic [2:0] CSR_TOL    = 3'd7;

   localparam logic [1:0]  RST_OWN    = 2'd0;
   localparam logic [23:0] RST_SCALE  = 24'd65536;
   localparam logic [15:0] RST_AGAIN  = 16'd205;
   localparam logic [15:0] RST_CGAIN  = 16'd768;
   localparam logic [15:0] RST_TGAIN  = 16'd640;
   localparam logic [15:0] RST_SGAIN  = 16'd128;
   localparam logic [31:0] RST_LIMITS = 32'd483197829;
   localparam logic [31:0] RST_TOL    = 32'd53675213;

   typedef enum logic [4:0] {
      OP_NONE, OP_GLOAD, OP_NORM, OP_SQX, OP_SQY, OP_ROOTI, OP_ROOT, OP_LEN,
      OP_DIVXI, OP_DIV, OP_DIVYI, OP_GFORCE, OP_CDIFF, OP_CACC, OP_FLOAD,
      OP_ADN, OP_AUP, OP_CI, OP_CORDIC, OP_ANG, OP_YERR, OP_TURN, OP_SPL,
      OP_SPH, OP_ZERO, OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [4:0] idx;
   } dp_cmd_type;

   typedef struct packed {
      logic eligible;
      logic norm_done;
      logic goal_far;
      logic len_small;
      logic nb_ok;
      logic ang_big;
      logic ang_small;
   } dp_stat_type;

   function automatic logic [15:0] atan_q16(input logic [4:0] i);
      logic [15:0] v;
      case (i)
         5'd0:    v = 16'd51472;
         5'd1:    v = 16'd30386;
         5'd2:    v = 16'd16055;
         5'd3:    v = 16'd8150;
         5'd4:    v = 16'd4091;
         5'd5:    v = 16'd2047;
         5'd6:    v = 16'd1024;
         5'd7:    v = 16'd512;
         5'd8:    v = 16'd256;
         5'd9:    v = 16'd128;
         5'd10:   v = 16'd64;
         5'd11:   v = 16'd32;
         5'd12:   v = 16'd16;
         5'd13:   v = 16'd8;
         5'd14:   v = 16'd4;
         5'd15:   v = 16'd2;
         5'd16:   v = 16'd1;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

   function automatic logic slot_ok(input logic [1:0] r, input logic tri_m);
      return !tri_m || (r != 2'd2);
   endfunction

   function automatic logic signed [26:0] slot_x(input logic [1:0] r, input logic tri_m,
                                                 input logic [23:0] d);
      logic signed [26:0] dd;
      logic signed [26:0] v;
      dd = $signed({3'b000, d});
      if (tri_m) begin
         case (r)
            2'd0:    v = dd;
            2'd1:    v = -dd;
            default: v = '0;
         endcase
      end else begin
         v = (r == 2'd0 || r == 2'd3) ? dd : -dd;
      end
      return v;
   endfunction

   function automatic logic signed [26:0] slot_y(input logic [1:0] r, input logic tri_m,
                                                 input logic [23:0] d);
      logic signed [26:0] dd;
      logic signed [26:0] v;
      dd = $signed({3'b000, d});
      if (tri_m) begin
         case (r)
            2'd0, 2'd1: v = dd;
            2'd3:       v = -(dd <<< 1);
            default:    v = '0;
         endcase
      end else begin
         v = (r <= 2'd1) ? dd : -dd;
      end
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== src/fpfs_dp.sv =====
// Datapath: registers, stored poses, root/divide/CORDIC steps and output register.
// Depends on fpfs_pkg; driven by fpfs_ctrl commands.
`default_nettype none
module fpfs_dp import fpfs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_accept,
   input  logic [1:0]         req_mode,
   input  logic [1:0]         req_robot_index,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [14:0] req_heading,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wr_data,
   input  dp_cmd_type         cmd,
   output dp_stat_type        stat,
   output logic [14:0]        rsp_linear_cmd,
   output logic signed [15:0] rsp_angular_cmd
);

   logic [1:0]  own_ff;
   logic [23:0] scale_ff;
   logic [15:0] again_ff, cgain_ff, tgain_ff, sgain_ff;
   logic [31:0] slim_ff, tol_ff;

   logic signed [31:0] posx_ff [ROBOT_COUNT];
   logic signed [31:0] posy_ff [ROBOT_COUNT];
   logic signed [14:0] head_ff [ROBOT_COUNT];
   logic [3:0]  known_ff, excl_ff;
   logic signed [31:0] goalx_ff, goaly_ff;
   logic gknown_ff, tri_ff, halt_ff;

   logic signed [31:0] px_ff, py_ff;
   logic signed [14:0] hd_ff;
   logic [47:0] mx_ff, my_ff;
   logic [4:0]  sh_ff;
   logic [63:0] sum_ff, rem_ff, r_ff, bit_ff;
   logic [48:0] len_ff;
   logic [32:0] drem_ff;
   logic [16:0] nb_ff, q_ff, ux_ff;
   logic gsx_ff, gsy_ff, fsx_ff, fsy_ff;
   logic signed [47:0] fx_ff, fy_ff;
   logic signed [34:0] ex_ff, ey_ff;
   logic signed [31:0] cx_ff, cy_ff;
   logic signed [19:0] z_ff;
   logic signed [16:0] angq_ff;
   logic signed [15:0] yerr_ff;
   logic aligned_ff;
   logic [39:0] plo_ff;
   logic [14:0] lin_ff, out_lin_ff;
   logic signed [15:0] ang_ff, out_ang_ff;

   logic [1:0]  rsel, jj;
   logic signed [31:0] rdx, rdy;
   logic signed [32:0] gdx, gdy;
   logic [32:0] agdx, agdy;
   logic [47:0] mxy, afx, afy;
   logic [61:0] sqx, sqy;
   logic [63:0] trial;
   logic [32:0] dt;
   logic [32:0] gpx, gpy;
   logic [47:0] gxs, gys;
   logic signed [26:0] offx, offy;
   logic signed [51:0] cpx, cpy;
   logic signed [31:0] xs, ys;
   logic signed [19:0] at;
   logic signed [20:0] a0, a1, a2;
   logic [20:0] am;
   logic [16:0] aq;
   logic signed [17:0] ye;
   logic signed [32:0] tp;
   logic signed [24:0] tt, lims;
   logic [14:0] lim15, vl15;
   logic [15:0] yabs;
   logic [40:0] phi;
   logic [64:0] tot;
   logic [52:0] vv;

   always_comb begin
      rsel = (cmd.op == OP_CDIFF) ? cmd.idx[1:0] : own_ff;
      jj   = cmd.idx[1:0];
      rdx  = posx_ff[rsel];
      rdy  = posy_ff[rsel];
      gdx  = {goalx_ff[31], goalx_ff} - {rdx[31], rdx};
      gdy  = {goaly_ff[31], goaly_ff} - {rdy[31], rdy};
      agdx = gdx[32] ? (~gdx + 33'd1) : gdx;
      agdy = gdy[32] ? (~gdy + 33'd1) : gdy;
      mxy  = (mx_ff > my_ff) ? mx_ff : my_ff;
      afx  = fx_ff[47] ? (~fx_ff + 48'd1) : fx_ff;
      afy  = fy_ff[47] ? (~fy_ff + 48'd1) : fy_ff;
      sqx  = mx_ff[30:0] * mx_ff[30:0];
      sqy  = my_ff[30:0] * my_ff[30:0];
      trial = r_ff + bit_ff;
      dt   = {drem_ff[31:0], nb_ff[16]};
      gpx  = again_ff * ux_ff;
      gpy  = again_ff * q_ff;
      gxs  = {23'd0, gpx[32:8]};
      gys  = {23'd0, gpy[32:8]};
      offx = slot_x(own_ff, tri_ff, scale_ff) - slot_x(jj, tri_ff, scale_ff);
      offy = slot_y(own_ff, tri_ff, scale_ff) - slot_y(jj, tri_ff, scale_ff);
      cpx  = $signed({1'b0, cgain_ff}) * ex_ff;
      cpy  = $signed({1'b0, cgain_ff}) * ey_ff;
      xs   = cx_ff >>> cmd.idx;
      ys   = cy_ff >>> cmd.idx;
      at   = $signed({4'd0, atan_q16(cmd.idx)});
      a0   = {z_ff[19], z_ff};
      a1   = fsx_ff ? (21'sd205887 - a0) : a0;
      a2   = fsy_ff ? -a1 : a1;
      am   = a2[20] ? (~a2 + 21'd1) : a2;
      aq   = 17'((am + 21'd8) >> 4);
      ye   = {angq_ff[16], angq_ff} - {{3{hd_ff[14]}}, hd_ff};
      tp   = $signed({1'b0, tgain_ff}) * yerr_ff;
      tt   = tp[32:8];
      lim15 = slim_ff[31] ? 15'h7fff : slim_ff[30:16];
      vl15  = slim_ff[15] ? 15'h7fff : slim_ff[14:0];
      lims = $signed({10'd0, lim15});
      yabs = yerr_ff[15] ? (~yerr_ff + 16'd1) : yerr_ff;
      phi  = sgain_ff * len_ff[48:24];
      tot  = {phi, 24'd0} + {25'd0, plo_ff};
      vv   = tot[64:12];
   end

   always_comb begin
      stat.eligible  = !halt_ff && known_ff[own_ff] && gknown_ff;
      stat.norm_done = (mxy[47:31] == '0);
      stat.goal_far  = (len_ff > {29'd0, tol_ff[15:0], 4'd0}) && (r_ff != '0);
      stat.len_small = (len_ff < 49'(FORCE_EPS));
      stat.nb_ok     = (jj != own_ff) && !excl_ff[jj] && known_ff[jj]
                       && slot_ok(jj, tri_ff) && slot_ok(own_ff, tri_ff);
      stat.ang_big   = (mxy[47:28] != '0);
      stat.ang_small = (mxy[47:27] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff   <= RST_OWN;
         scale_ff <= RST_SCALE;
         again_ff <= RST_AGAIN;
         cgain_ff <= RST_CGAIN;
         tgain_ff <= RST_TGAIN;
         sgain_ff <= RST_SGAIN;
         slim_ff  <= RST_LIMITS;
         tol_ff   <= RST_TOL;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_OWN:    own_ff   <= csr_wr_data[1:0];
            CSR_SCALE:  scale_ff <= csr_wr_data[23:0];
            CSR_AGAIN:  again_ff <= csr_wr_data[15:0];
            CSR_CGAIN:  cgain_ff <= csr_wr_data[15:0];
            CSR_TGAIN:  tgain_ff <= csr_wr_data[15:0];
            CSR_SGAIN:  sgain_ff <= csr_wr_data[15:0];
            CSR_LIMITS: slim_ff  <= csr_wr_data;
            CSR_TOL:    tol_ff   <= csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff  <= '0;
         excl_ff   <= '0;
         gknown_ff <= 1'b0;
         tri_ff    <= 1'b0;
         halt_ff   <= 1'b0;
      end else if (req_accept) begin
         case (req_mode)
            MODE_POSE: known_ff[req_robot_index] <= 1'b1;
            MODE_EXCL: begin
               excl_ff[req_robot_index] <= 1'b1;
               if (req_robot_index == own_ff) halt_ff <= 1'b1;
               else tri_ff <= 1'b1;
            end
            MODE_GOAL: gknown_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_mode == MODE_POSE) begin
         posx_ff[req_robot_index] <= req_pos_x;
         posy_ff[req_robot_index] <= req_pos_y;
         head_ff[req_robot_index] <= req_heading;
      end
      if (req_accept && req_mode == MODE_GOAL) begin
         goalx_ff <= req_pos_x;
         goaly_ff <= req_pos_y;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_GLOAD: begin
            px_ff  <= rdx;
            py_ff  <= rdy;
            hd_ff  <= head_ff[own_ff];
            mx_ff  <= {15'd0, agdx};
            my_ff  <= {15'd0, agdy};
            gsx_ff <= gdx[32];
            gsy_ff <= gdy[32];
            sh_ff  <= '0;
            fx_ff  <= '0;
            fy_ff  <= '0;
         end
         OP_NORM: begin
            if (!stat.norm_done) begin
               mx_ff <= mx_ff >> 1;
               my_ff <= my_ff >> 1;
               sh_ff <= sh_ff + 5'd1;
            end
         end
         OP_SQX: sum_ff <= {2'd0, sqx};
         OP_SQY: sum_ff <= sum_ff + {2'd0, sqy};
         OP_ROOTI: begin
            rem_ff <= sum_ff;
            r_ff   <= '0;
            bit_ff <= 64'h4000_0000_0000_0000;
         end
         OP_ROOT: begin
            if (rem_ff >= trial) begin
               rem_ff <= rem_ff - trial;
               r_ff   <= (r_ff >> 1) + bit_ff;
            end else begin
               r_ff <= r_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         OP_LEN: len_ff <= {17'd0, r_ff[31:0]} << sh_ff;
         OP_DIVXI: begin
            drem_ff <= {3'd0, mx_ff[30:1]};
            nb_ff   <= {mx_ff[0], 16'd0};
            q_ff    <= '0;
         end
         OP_DIVYI: begin
            ux_ff   <= q_ff;
            drem_ff <= {3'd0, my_ff[30:1]};
            nb_ff   <= {my_ff[0], 16'd0};
            q_ff    <= '0;
         end
         OP_DIV: begin
            if (dt >= {1'b0, r_ff[31:0]}) begin
               drem_ff <= dt - {1'b0, r_ff[31:0]};
               q_ff    <= {q_ff[15:0], 1'b1};
            end else begin
               drem_ff <= dt;
               q_ff    <= {q_ff[15:0], 1'b0};
            end
            nb_ff <= nb_ff << 1;
         end
         OP_GFORCE: begin
            fx_ff <= gsx_ff ? -$signed(gxs) : $signed(gxs);
            fy_ff <= gsy_ff ? -$signed(gys) : $signed(gys);
         end
         OP_CDIFF: begin
            ex_ff <= {{3{rdx[31]}}, rdx} + {{8{offx[26]}}, offx} - {{3{px_ff[31]}}, px_ff};
            ey_ff <= {{3{rdy[31]}}, rdy} + {{8{offy[26]}}, offy} - {{3{py_ff[31]}}, py_ff};
         end
         OP_CACC: begin
            fx_ff <= fx_ff + {{4{cpx[51]}}, cpx[51:8]};
            fy_ff <= fy_ff + {{4{cpy[51]}}, cpy[51:8]};
         end
         OP_FLOAD: begin
            mx_ff  <= afx;
            my_ff  <= afy;
            fsx_ff <= fx_ff[47];
            fsy_ff <= fy_ff[47];
            sh_ff  <= '0;
         end
         OP_ADN: begin
            if (stat.ang_big) begin
               mx_ff <= mx_ff >> 1;
               my_ff <= my_ff >> 1;
            end
         end
         OP_AUP: begin
            if (stat.ang_small) begin
               mx_ff <= mx_ff << 1;
               my_ff <= my_ff << 1;
            end
         end
         OP_CI: begin
            cx_ff <= $signed({4'd0, mx_ff[27:0]});
            cy_ff <= $signed({4'd0, my_ff[27:0]});
            z_ff  <= '0;
         end
         OP_CORDIC: begin
            if (cy_ff > 0) begin
               cx_ff <= cx_ff + ys;
               cy_ff <= cy_ff - xs;
               z_ff  <= z_ff + at;
            end else begin
               cx_ff <= cx_ff - ys;
               cy_ff <= cy_ff + xs;
               z_ff  <= z_ff - at;
            end
         end
         OP_ANG: angq_ff <= a2[20] ? -$signed(aq) : $signed(aq);
         OP_YERR: begin
            if (ye > 18'sd12868) yerr_ff <= 16'(ye - 18'sd25736);
            else if (ye < -18'sd12868) yerr_ff <= 16'(ye + 18'sd25736);
            else yerr_ff <= 16'(ye);
         end
         OP_TURN: begin
            if (tt > lims) ang_ff <= 16'(lims);
            else if (tt < -lims) ang_ff <= 16'(-lims);
            else ang_ff <= 16'(tt);
            aligned_ff <= (yabs <= tol_ff[31:16]);
         end
         OP_SPL: plo_ff <= sgain_ff * len_ff[23:0];
         OP_SPH: begin
            if (!aligned_ff) lin_ff <= '0;
            else if (vv < {38'd0, vl15}) lin_ff <= vv[14:0];
            else lin_ff <= vl15;
         end
         OP_ZERO: begin
            lin_ff <= '0;
            ang_ff <= '0;
         end
         OP_OUT: begin
            out_lin_ff <= lin_ff;
            out_ang_ff <= ang_ff;
         end
         default: ;
      endcase
   end

   assign rsp_linear_cmd  = out_lin_ff;
   assign rsp_angular_cmd = out_ang_ff;

endmodule
`default_nettype wire

// ===== src/fpfs_ctrl.sv =====
// Controller: sequences one item at a time through the datapath and owns the handshakes.
// Depends on fpfs_pkg and the assertion macro header.
`default_nettype none
`include "formation_potential_field_steering_defines.svh"
module fpfs_ctrl import fpfs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [28:0] {
      S_IDLE  = 29'd1 << 0,  S_GLOAD = 29'd1 << 1,  S_NORM  = 29'd1 << 2,
      S_SQX   = 29'd1 << 3,  S_SQY   = 29'd1 << 4,  S_ROOTI = 29'd1 << 5,
      S_ROOT  = 29'd1 << 6,  S_LEN   = 29'd1 << 7,  S_BR    = 29'd1 << 8,
      S_DIVXI = 29'd1 << 9,  S_DIVX  = 29'd1 << 10, S_DIVYI = 29'd1 << 11,
      S_DIVY  = 29'd1 << 12, S_GF    = 29'd1 << 13, S_CD    = 29'd1 << 14,
      S_CA    = 29'd1 << 15, S_FLOAD = 29'd1 << 16, S_ALOAD = 29'd1 << 17,
      S_ADN   = 29'd1 << 18, S_AUP   = 29'd1 << 19, S_CI    = 29'd1 << 20,
      S_CR    = 29'd1 << 21, S_ANG   = 29'd1 << 22, S_YERR  = 29'd1 << 23,
      S_TURN  = 29'd1 << 24, S_SPL   = 29'd1 << 25, S_SPH   = 29'd1 << 26,
      S_ZERO  = 29'd1 << 27, S_DONE  = 29'd1 << 28
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       ph_ff, ph_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       load;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ph_in    = ph_ff;
      load     = 1'b0;
      cmd.op   = OP_NONE;
      cmd.idx  = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_mode == MODE_TICK)
               state_in = stat.eligible ? S_GLOAD : S_ZERO;
         end
         S_GLOAD: begin
            cmd.op = OP_GLOAD; ph_in = 1'b0; state_in = S_NORM;
         end
         S_NORM: begin
            cmd.op = OP_NORM;
            if (stat.norm_done) state_in = S_SQX;
         end
         S_SQX:   begin cmd.op = OP_SQX; state_in = S_SQY; end
         S_SQY:   begin cmd.op = OP_SQY; state_in = S_ROOTI; end
         S_ROOTI: begin cmd.op = OP_ROOTI; cnt_in = '0; state_in = S_ROOT; end
         S_ROOT: begin
            cmd.op = OP_ROOT; cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == ROOT_LAST) state_in = S_LEN;
         end
         S_LEN: begin cmd.op = OP_LEN; state_in = S_BR; end
         S_BR: begin
            cnt_in = '0;
            if (!ph_ff) state_in = stat.goal_far ? S_DIVXI : S_CD;
            else state_in = stat.len_small ? S_ZERO : S_ALOAD;
         end
         S_DIVXI: begin cmd.op = OP_DIVXI; cnt_in = '0; state_in = S_DIVX; end
         S_DIVX: begin
            cmd.op = OP_DIV; cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == DIV_LAST) state_in = S_DIVYI;
         end
         S_DIVYI: begin cmd.op = OP_DIVYI; cnt_in = '0; state_in = S_DIVY; end
         S_DIVY: begin
            cmd.op = OP_DIV; cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == DIV_LAST) state_in = S_GF;
         end
         S_GF: begin cmd.op = OP_GFORCE; cnt_in = '0; state_in = S_CD; end
         S_CD: begin
            cmd.op = OP_CDIFF;
            if (stat.nb_ok) state_in = S_CA;
            else if (cnt_ff == ROBOT_LAST) state_in = S_FLOAD;
            else cnt_in = cnt_ff + 5'd1;
         end
         S_CA: begin
            cmd.op = OP_CACC;
            if (cnt_ff == ROBOT_LAST) state_in = S_FLOAD;
            else begin
               cnt_in = cnt_ff + 5'd1; state_in = S_CD;
            end
         end
         S_FLOAD: begin cmd.op = OP_FLOAD; ph_in = 1'b1; state_in = S_NORM; end
         S_ALOAD: begin cmd.op = OP_FLOAD; state_in = S_ADN; end
         S_ADN: begin
            cmd.op = OP_ADN;
            if (!stat.ang_big) state_in = S_AUP;
         end
         S_AUP: begin
            cmd.op = OP_AUP;
            if (!stat.ang_small) state_in = S_CI;
         end
         S_CI: begin cmd.op = OP_CI; cnt_in = '0; state_in = S_CR; end
         S_CR: begin
            cmd.op = OP_CORDIC; cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == CORDIC_LAST) state_in = S_ANG;
         end
         S_ANG:  begin cmd.op = OP_ANG; state_in = S_YERR; end
         S_YERR: begin cmd.op = OP_YERR; state_in = S_TURN; end
         S_TURN: begin cmd.op = OP_TURN; state_in = S_SPL; end
         S_SPL:  begin cmd.op = OP_SPL; state_in = S_SPH; end
         S_SPH:  begin cmd.op = OP_SPH; state_in = S_DONE; end
         S_ZERO: begin cmd.op = OP_ZERO; state_in = S_DONE; end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op = OP_OUT; load = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         ph_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ph_ff        <= ph_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `FPFS_ASSERT(a_tick_start, clock, reset, (req_valid && req_ready && req_mode == MODE_TICK && stat.eligible) |=> state_ff == S_GLOAD)
   `FPFS_ASSERT(a_root_end, clock, reset, (state_ff == S_ROOT && cnt_ff == ROOT_LAST) |=> state_ff == S_LEN)
   `FPFS_ASSERT(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))

endmodule
`default_nettype wire

// ===== src/formation_potential_field_steering.sv =====
// Pose, goal and exclusion items are stored when accepted and give no result. A tick item
// runs through a shared sequencer: two length computations with a 32-step square root each,
// two 17-step divides for the goal unit vector, up to three cohesion terms, a 17-step CORDIC
// and a few shift-normalisation steps, the two square-root loops and the divides taking most
// of its time; a tick whose command is zero by rule skips all of these steps, and one that
// ends on a tiny force skips the angle and speed steps; both give a zero command.
// One item is in flight at a time; a finished result sits in an output
// register, and pose, goal and exclusion items are taken while it waits.
// Top level of the formation steering block; depends on fpfs_pkg, fpfs_ctrl and fpfs_dp.
`default_nettype none
module formation_potential_field_steering import fpfs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   input  logic [1:0]         req_robot_index,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [14:0] req_heading,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [14:0]        rsp_linear_cmd,
   output logic signed [15:0] rsp_angular_cmd,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wr_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   fpfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fpfs_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_accept      (req_valid && req_ready),
      .req_mode        (req_mode),
      .req_robot_index (req_robot_index),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_heading     (req_heading),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_linear_cmd  (rsp_linear_cmd),
      .rsp_angular_cmd (rsp_angular_cmd)
   );

endmodule
`default_nettype wire
